// ===== rtl/mts_pkg.sv =====
// Shared types and constants of the melody tone sequencer.
package mts_pkg;

    localparam int DEF_NOTES         = 256;
    localparam int DEF_TONE_CLOCK_HZ = 1000000;

    localparam int FREQ_W     = 16;
    localparam int BEATS_W    = 8;
    localparam int INDEX_W    = 8;
    localparam int NOTE_PTR_W = 9;
    localparam int TIMER_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = FREQ_W + BEATS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SONG_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_PERIOD   = 1'b1;
    localparam logic [TIMER_W-1:0]   RELOAD_RESET      = 16'hFFFF;
    localparam logic [TIMER_W-1:0]   BEAT_PERIOD_RESET = 16'd500;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_START  = 2'd2,
        OP_TOGGLE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [INDEX_W-1:0] note_index;
        logic [FREQ_W-1:0]  note_freq;
        logic [BEATS_W-1:0] note_beats;
    } t_in_word;

    typedef struct packed {
        logic [TIMER_W-1:0]    period_reload;
        logic [TIMER_W-1:0]    duty_compare;
        logic                  audible;
        logic [NOTE_PTR_W-1:0] current_note;
    } t_out_word;

    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [BEATS_W-1:0] beats;
    } t_note;

    typedef struct packed {
        logic               start;
        logic [FREQ_W-1:0]  freq;
        logic [BEATS_W-1:0] beats;
        logic [TIMER_W-1:0] beat_ms;
    } t_arith_req;

    typedef struct packed {
        logic               done;
        logic [TIMER_W-1:0] period;
        logic [TIMER_W-1:0] duration;
    } t_arith_rsp;

endpackage

// ===== rtl/mts_note_store.sv =====
// Note table memory with one write port and one registered read port.
module mts_note_store #(
    parameter int DEPTH = mts_pkg::DEF_NOTES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  mts_pkg::t_note i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output mts_pkg::t_note o_rdata
);
    import mts_pkg::*;

    t_note r_mem [DEPTH];
    t_note r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mts_serial_arith.sv =====
// Bit-serial period divider and duration shift-add multiplier.
module mts_serial_arith #(
    parameter int TONE_CLOCK_HZ = mts_pkg::DEF_TONE_CLOCK_HZ
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mts_pkg::t_arith_req i_req,
    output mts_pkg::t_arith_rsp o_rsp
);
    import mts_pkg::*;

    localparam int DIV_W = $clog2(TONE_CLOCK_HZ + 1);
    localparam int QW    = (DIV_W > TIMER_W) ? DIV_W : TIMER_W;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TONE_CLOCK_HZ);

    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [FREQ_W-1:0]  r_divisor;
    logic [FREQ_W:0]    r_rem;
    logic [DIV_W-1:0]   r_dvd;
    logic [DIV_W-1:0]   r_quot;
    logic [PROD_W-1:0]  r_mcand;
    logic [BEATS_W-1:0] r_mplier;
    logic [PROD_W-1:0]  r_acc;

    logic [FREQ_W:0]    n_rem_sh;
    logic               n_ge;
    logic [QW-1:0]      n_q_m1;

    assign n_rem_sh = {r_rem[FREQ_W-1:0], r_dvd[DIV_W-1]};
    assign n_ge     = (n_rem_sh >= {1'b0, r_divisor});
    assign n_q_m1   = QW'(r_quot) - QW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= CNT_W'(DIV_W);
                r_divisor <= i_req.freq;
                r_rem     <= '0;
                r_dvd     <= DIVIDEND;
                r_quot    <= '0;
                r_mcand   <= PROD_W'(i_req.beat_ms);
                r_mplier  <= i_req.beats;
                r_acc     <= '0;
            end else if (r_busy) begin
                r_rem    <= n_ge ? (n_rem_sh - {1'b0, r_divisor}) : n_rem_sh;
                r_quot   <= {r_quot[DIV_W-2:0], n_ge};
                r_dvd    <= {r_dvd[DIV_W-2:0], 1'b0};
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[BEATS_W-1:1]};
                r_cnt    <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.period   = n_q_m1[TIMER_W-1:0];
    assign o_rsp.duration = r_acc[TIMER_W+1:2];

endmodule

// ===== rtl/melody_tone_sequencer_unit.sv =====
// Top level of the melody tone sequencer with its control sequencer and registers.
//
// Every input word returns exactly one output word that shows the timer state after it.
// A tick at the first millisecond of a note passes through DECODE, FETCH, LAUNCH, CALC, APPLY,
// ADVANCE and FINISH, and waits in CALC while the bit-serial divider and multiplier run over
// the DIV_W bits of TONE_CLOCK_HZ. A note write passes through DECODE, MOD, WRITE and FINISH,
// where MOD reduces the slot index bit-serially modulo NOTES; any other tick that plays passes
// through DECODE, ADVANCE and FINISH, and all other words through DECODE and FINISH.
// The input is stalled until the output word is presented, and the next word can be accepted
// in the cycle after that. A new input word is taken while the previous output word still
// waits, and a stalled output holds the next result back. Configuration writes are always
// ready and take effect at once.
module melody_tone_sequencer_unit #(
    parameter int NOTES         = mts_pkg::DEF_NOTES,
    parameter int TONE_CLOCK_HZ = mts_pkg::DEF_TONE_CLOCK_HZ
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  mts_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mts_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mts_pkg::*;

    localparam int SLOT_W = $clog2(NOTES);
    localparam int BIT_W  = $clog2(INDEX_W);
    localparam logic [SLOT_W:0]   NOTES_C   = (SLOT_W + 1)'(NOTES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NOTES - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_WRITE,
        ST_FETCH,
        ST_LAUNCH,
        ST_CALC,
        ST_APPLY,
        ST_ADVANCE,
        ST_FINISH
    } t_state;

    t_state                r_state;
    t_in_word              r_word;
    logic [NOTE_PTR_W-1:0] r_song_len;
    logic [TIMER_W-1:0]    r_beat_ms;
    logic [NOTE_PTR_W-1:0] r_ptr;
    logic [SLOT_W-1:0]     r_slot;
    logic [TIMER_W-1:0]    r_elapsed;
    logic [TIMER_W-1:0]    r_duration;
    logic [TIMER_W-1:0]    r_held_period;
    logic [TIMER_W-1:0]    r_reload;
    logic [TIMER_W-1:0]    r_compare;
    logic                  r_running;
    logic                  r_held;
    logic [SLOT_W:0]       r_rem;
    logic [INDEX_W-1:0]    r_idx_sr;
    logic [BIT_W-1:0]      r_bit_cnt;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                  n_in_take;
    logic                  n_out_free;
    logic [SLOT_W:0]       n_rem_sh;
    logic [TIMER_W-1:0]    n_elapsed;
    t_note                 n_wdata;
    t_note                 n_rdata;
    t_arith_req            n_req;
    t_arith_rsp            n_rsp;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign n_in_take   = i_in_valid && (r_state == ST_IDLE);
    assign n_out_free  = !r_out_valid || !i_out_stall;
    assign n_rem_sh    = {r_rem[SLOT_W-1:0], r_idx_sr[INDEX_W-1]};
    assign n_elapsed   = r_elapsed + TIMER_W'(1);
    assign n_wdata     = '{freq: r_word.note_freq, beats: r_word.note_beats};
    assign o_cfg_ready = 1'b1;

    assign n_req.start   = (r_state == ST_LAUNCH);
    assign n_req.freq    = n_rdata.freq;
    assign n_req.beats   = n_rdata.beats;
    assign n_req.beat_ms = r_beat_ms;

    mts_note_store #(
        .DEPTH (NOTES),
        .AW    (SLOT_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WRITE),
        .i_waddr (r_rem[SLOT_W-1:0]),
        .i_wdata (n_wdata),
        .i_re    (r_state == ST_FETCH),
        .i_raddr (r_slot),
        .o_rdata (n_rdata)
    );

    mts_serial_arith #(
        .TONE_CLOCK_HZ (TONE_CLOCK_HZ)
    ) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_rsp   (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_song_len    <= '0;
            r_beat_ms     <= BEAT_PERIOD_RESET;
            r_ptr         <= '0;
            r_slot        <= '0;
            r_elapsed     <= '0;
            r_duration    <= '0;
            r_held_period <= '0;
            r_reload      <= RELOAD_RESET;
            r_compare     <= '0;
            r_running     <= 1'b0;
            r_held        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SONG_LENGTH: r_song_len <= i_cfg_data[NOTE_PTR_W-1:0];
                    CFG_BEAT_PERIOD: r_beat_ms  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (n_in_take) begin
                        r_word  <= i_in_word;
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    unique case (r_word.operation)
                        OP_WRITE: begin
                            r_rem     <= '0;
                            r_idx_sr  <= r_word.note_index;
                            r_bit_cnt <= '0;
                            r_state   <= ST_MOD;
                        end
                        OP_START: begin
                            r_ptr         <= '0;
                            r_slot        <= '0;
                            r_running     <= 1'b1;
                            r_held        <= 1'b0;
                            r_elapsed     <= '0;
                            r_duration    <= '0;
                            r_held_period <= '0;
                            r_state       <= ST_FINISH;
                        end
                        OP_TOGGLE: begin
                            if (r_running) begin
                                r_held <= !r_held;
                                if (!r_held) begin
                                    r_compare <= '0;
                                end else if (r_held_period != '0) begin
                                    r_compare <= r_held_period >> 1;
                                end
                            end
                            r_state <= ST_FINISH;
                        end
                        OP_TICK: begin
                            priority if (!r_running || r_held) begin
                                r_state <= ST_FINISH;
                            end else if (r_ptr >= r_song_len) begin
                                r_running <= 1'b0;
                                r_compare <= '0;
                                r_state   <= ST_FINISH;
                            end else if (r_elapsed == '0) begin
                                r_state <= ST_FETCH;
                            end else begin
                                r_state <= ST_ADVANCE;
                            end
                        end
                        default: r_state <= ST_FINISH;
                    endcase
                end
                ST_MOD: begin
                    r_rem     <= (n_rem_sh >= NOTES_C) ? (n_rem_sh - NOTES_C) : n_rem_sh;
                    r_idx_sr  <= {r_idx_sr[INDEX_W-2:0], 1'b0};
                    r_bit_cnt <= r_bit_cnt + BIT_W'(1);
                    if (r_bit_cnt == BIT_W'(INDEX_W - 1)) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_state <= ST_FINISH;
                end
                ST_FETCH: begin
                    r_state <= ST_LAUNCH;
                end
                ST_LAUNCH: begin
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    if (n_rsp.done) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    r_duration <= n_rsp.duration;
                    if (n_rdata.freq == '0) begin
                        r_compare     <= '0;
                        r_held_period <= '0;
                    end else begin
                        r_held_period <= n_rsp.period;
                        r_reload      <= n_rsp.period;
                        r_compare     <= n_rsp.period >> 1;
                    end
                    r_state <= ST_ADVANCE;
                end
                ST_ADVANCE: begin
                    if (n_elapsed >= r_duration) begin
                        r_elapsed <= '0;
                        r_ptr     <= r_ptr + NOTE_PTR_W'(1);
                        if (r_ptr == '1 || r_slot == LAST_SLOT) begin
                            r_slot <= '0;
                        end else begin
                            r_slot <= r_slot + SLOT_W'(1);
                        end
                    end else begin
                        r_elapsed <= n_elapsed;
                    end
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (n_out_free) begin
                        r_out_valid              <= 1'b1;
                        r_out_word.period_reload <= r_reload;
                        r_out_word.duty_compare  <= r_compare;
                        r_out_word.audible       <= r_running && !r_held;
                        r_out_word.current_note  <= r_ptr;
                        r_state                  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
